// ===== src/wlan_frame_classifier_log_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame classifier modules
// Each expects clk and rst_n in scope; checks are off while in reset.
// ---------------------------------------------------------------------------
`ifndef WLAN_FRAME_CLASSIFIER_LOG_TOP_MACROS_SVH
`define WLAN_FRAME_CLASSIFIER_LOG_TOP_MACROS_SVH

// same-cycle implication
`define FLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/flc_pkg.sv =====
// ---------------------------------------------------------------------------
// flc_pkg
// Types, codes and field layouts shared by the frame classifier modules.
// ---------------------------------------------------------------------------
package flc_pkg;

  // default ring depth
  localparam int LOG_DEPTH_DFLT = 64;

  // request codes carried on in_tuser
  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_DRAIN = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // result kind carried on out_tuser
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // frame types from the frame control byte
  localparam logic [1:0] FT_MGMT = 2'd0;
  localparam logic [1:0] FT_CTRL = 2'd1;
  localparam logic [1:0] FT_DATA = 2'd2;

  // management subtypes that count as notable
  localparam logic [3:0] SUB_DISASSOC = 4'd10;
  localparam logic [3:0] SUB_DEAUTH   = 4'd12;

  // MAC header size in bytes
  localparam logic [11:0] HDR_BYTES = 12'd24;

  // counter bank
  localparam int CNT_W       = 32;
  localparam int NUM_CNT     = 5;
  localparam int CNT_TOTAL   = 0;
  localparam int CNT_MGMT    = 1;
  localparam int CNT_CTRL    = 2;
  localparam int CNT_DATA    = 3;
  localparam int CNT_NOTABLE = 4;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_bank_t;

  // request to the counter unit
  typedef struct packed {
    logic       clr;
    logic       bump;
    logic [1:0] ftype;
    logic [3:0] fsub;
  } cnt_ctrl_t;

  // one ring entry, type in the lowest bits (same order as out_tdata)
  typedef struct packed {
    logic [3:0]         channel;
    logic signed [7:0]  strength;
    logic [47:0]        address;
    logic [3:0]         subtype;
    logic [1:0]         ftype;
  } log_entry_t;

  localparam int ENTRY_W = $bits(log_entry_t);

  // stream widths
  localparam int IN_DATA_W   = 80;
  localparam int OUT_FIELD_W = ENTRY_W + NUM_CNT * CNT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD     = OUT_DATA_W - OUT_FIELD_W;

endpackage

// ===== src/wlan_frame_classifier_log_top.sv =====
// ---------------------------------------------------------------------------
// wlan_frame_classifier_log_top
// 802.11 frame classifier with class counters and a capture ring.
// ---------------------------------------------------------------------------
// A received frame, a clear or a counter read is taken while the block is
// idle; a counter read passes to a report state, which loads the report into
// the output register as soon as that register is free. A drain reads the
// logged entries oldest first; every entry costs a read of the ring RAM
// (registered read data) and a load of the output register.
// No request is taken during a drain or a pending report. The ring needs no
// clearing pass after reset: only entries below the fill count are read.
// ---------------------------------------------------------------------------
`include "wlan_frame_classifier_log_top_macros.svh"

module wlan_frame_classifier_log_top #(
  parameter int LOG_DEPTH = flc_pkg::LOG_DEPTH_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [11:0] frame_length, [19:12] frame_control_byte, [67:20] source_address,
  // [75:68] signal_strength, [79:76] radio_channel
  input  logic [flc_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] action
  input  logic [1:0]                    in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] logged_type, [5:2] logged_subtype, [53:6] logged_address,
  // [61:54] logged_strength, [65:62] logged_channel, [97:66] total_count,
  // [129:98] management_count, [161:130] control_count,
  // [193:162] data_count, [225:194] notable_count, [231:226] zero
  output logic [flc_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] report_kind
  output logic                          out_tuser,
  output logic                          out_tlast,
  // configuration: capture_enable
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int FW = AW + 1;
  localparam logic [FW-1:0] DEPTH_F  = FW'(LOG_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(LOG_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_LOAD,
    S_REPORT
  } state_t;

  state_t  state_r, state_nxt;
  logic    cap_en_r, cap_en_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] remain_r, remain_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_kind_r, out_kind_nxt;
  logic    out_last_r, out_last_nxt;
  logic [flc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // request fields
  logic [11:0]        in_len;
  logic [7:0]         in_fcb;
  logic [47:0]        in_addr;
  logic signed [7:0]  in_str;
  logic [3:0]         in_chan;
  flc_pkg::action_t   in_act;

  assign in_len  = in_tdata[11:0];
  assign in_fcb  = in_tdata[19:12];
  assign in_addr = in_tdata[67:20];
  assign in_str  = in_tdata[75:68];
  assign in_chan = in_tdata[79:76];
  assign in_act  = flc_pkg::action_t'(in_tuser);

  logic in_accept;
  logic frame_ok;
  logic slot_free;
  logic [FW-1:0] start_sum;
  logic [AW-1:0] drain_start;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign frame_ok  = cap_en_r && (in_len >= flc_pkg::HDR_BYTES);
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // oldest entry: head minus fill, modulo depth
  assign start_sum   = {1'b0, head_r} + DEPTH_F - fill_r;
  assign drain_start = (start_sum >= DEPTH_F) ? AW'(start_sum - DEPTH_F)
                                              : start_sum[AW-1:0];

  // ring RAM
  logic                     ram_we;
  logic                     ram_re;
  flc_pkg::log_entry_t      ram_wdata;
  logic [flc_pkg::ENTRY_W-1:0] ram_rdata;

  assign ram_wdata = '{channel:  in_chan,
                       strength: in_str,
                       address:  in_addr,
                       subtype:  in_fcb[7:4],
                       ftype:    in_fcb[3:2]};

  flc_ram #(
    .WIDTH (flc_pkg::ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // counters
  flc_pkg::cnt_ctrl_t cnt_ctrl;
  flc_pkg::cnt_bank_t cnt_bank;

  flc_cnt u_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (cnt_ctrl),
    .counts (cnt_bank)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cap_en_nxt    = cap_en_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    rd_ptr_nxt    = rd_ptr_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    cnt_ctrl      = '{clr: 1'b0, bump: 1'b0, ftype: in_fcb[3:2], fsub: in_fcb[7:4]};

    if (cfg_valid) begin
      cap_en_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_act)
            flc_pkg::ACT_FRAME: begin
              if (frame_ok) begin
                cnt_ctrl.bump = 1'b1;
                ram_we        = 1'b1;
                head_nxt      = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
                if (fill_r != DEPTH_F) begin
                  fill_nxt = fill_r + 1'b1;
                end
              end
            end
            flc_pkg::ACT_DRAIN: begin
              if (fill_r != '0) begin
                rd_ptr_nxt = drain_start;
                remain_nxt = fill_r;
                state_nxt  = S_RD;
              end
            end
            flc_pkg::ACT_READ: begin
              state_nxt = S_REPORT;
            end
            flc_pkg::ACT_CLEAR: begin
              cnt_ctrl.clr = 1'b1;
              head_nxt     = '0;
              fill_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = flc_pkg::KIND_ENTRY;
          out_last_nxt  = (remain_r == FW'(1));
          out_data_nxt  = {{flc_pkg::OUT_PAD{1'b0}},
                           {(flc_pkg::NUM_CNT * flc_pkg::CNT_W){1'b0}},
                           ram_rdata};
          if (remain_r == FW'(1)) begin
            head_nxt  = '0;
            fill_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
            remain_nxt = remain_r - 1'b1;
            state_nxt  = S_RD;
          end
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = flc_pkg::KIND_REPORT;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {{flc_pkg::OUT_PAD{1'b0}}, cnt_bank,
                           {flc_pkg::ENTRY_W{1'b0}}};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_en_r    <= 1'b1;
      head_r      <= '0;
      fill_r      <= '0;
      rd_ptr_r    <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_en_r    <= cap_en_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;

  `FLC_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= DEPTH_F, "ring fill above depth")
  `FLC_ASSERT_NOW(a_write_idle, ram_we, state_r == S_IDLE, "ring write outside idle")
  `FLC_ASSERT_NOW(a_load_remain, state_r == S_LOAD, remain_r != '0, "drain with no entries left")
  `FLC_ASSERT_NEXT(a_drain_empties, state_r == S_LOAD && slot_free && remain_r == FW'(1),
    fill_r == '0 && head_r == '0 && state_r == S_IDLE, "ring not empty after drain")

endmodule

// ===== src/flc_ram.sv =====
// ---------------------------------------------------------------------------
// flc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module flc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/flc_cnt.sv =====
// ---------------------------------------------------------------------------
// flc_cnt
// Class counters: decodes the frame type and bumps the wrapping counters.
// ---------------------------------------------------------------------------
`include "wlan_frame_classifier_log_top_macros.svh"

module flc_cnt (
  input  logic               clk,
  input  logic               rst_n,
  input  flc_pkg::cnt_ctrl_t ctrl,
  output flc_pkg::cnt_bank_t counts
);

  flc_pkg::cnt_bank_t cnt_r;
  flc_pkg::cnt_bank_t cnt_nxt;
  logic [flc_pkg::NUM_CNT-1:0] hit;

  // which counters this frame touches
  always_comb begin
    hit = '0;
    hit[flc_pkg::CNT_TOTAL]   = 1'b1;
    hit[flc_pkg::CNT_MGMT]    = (ctrl.ftype == flc_pkg::FT_MGMT);
    hit[flc_pkg::CNT_CTRL]    = (ctrl.ftype == flc_pkg::FT_CTRL);
    hit[flc_pkg::CNT_DATA]    = (ctrl.ftype == flc_pkg::FT_DATA);
    hit[flc_pkg::CNT_NOTABLE] = (ctrl.ftype == flc_pkg::FT_MGMT) &&
                                ((ctrl.fsub == flc_pkg::SUB_DISASSOC) ||
                                 (ctrl.fsub == flc_pkg::SUB_DEAUTH));
  end

  // clear wins; otherwise increment the selected counters
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.clr) begin
      cnt_nxt = '0;
    end else if (ctrl.bump) begin
      for (int i = 0; i < flc_pkg::NUM_CNT; i++) begin
        if (hit[i]) begin
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign counts = cnt_r;

  `FLC_ASSERT_NEXT(a_clr_zero, ctrl.clr, cnt_r == '0, "counters not zero after clear")
  `FLC_ASSERT_NEXT(a_total_step, ctrl.bump && !ctrl.clr,
    cnt_r[flc_pkg::CNT_TOTAL] == $past(cnt_r[flc_pkg::CNT_TOTAL]) + 1'b1,
    "total counter did not step on an accepted frame")

endmodule

// ===== sim/tb_wlan_frame_classifier_log_top.sv =====
// ---------------------------------------------------------------------------
// tb_wlan_frame_classifier_log_top
// Self-checking bench for the frame classifier and capture ring. Requests
// go in on the input stream and results come back on the output stream.
// A scoreboard class keeps its own copy of the counters and the ring. Each
// accepted request adds the results it should cause, and each accepted
// result is compared field by field with the oldest one due. A directed
// part covers the corner cases. Random traffic follows under three idling
// patterns, with the capture enable switched between them.
// ---------------------------------------------------------------------------
module tb_wlan_frame_classifier_log_top;
  import flc_pkg::*;

  localparam int          CLK_HALF    = 4;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          IDLE_TAIL   = 16;
  localparam int          MAX_PRINTS  = 100;
  localparam logic [1:0]  FT_RSVD     = 2'd3;

  // output word, laid out as on out_tdata (entry in the lowest bits)
  typedef struct packed {
    logic [OUT_PAD-1:0] pad;
    logic [CNT_W-1:0]   notable;
    logic [CNT_W-1:0]   data_cnt;
    logic [CNT_W-1:0]   ctrl;
    logic [CNT_W-1:0]   mgmt;
    logic [CNT_W-1:0]   total;
    log_entry_t         entry;
  } out_word_t;

  typedef struct packed {
    logic      kind;
    logic      last;
    out_word_t word;
  } result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: predicts results from accepted requests and checks them
  // -------------------------------------------------------------------------
  class classifier_scoreboard;
    log_entry_t       ring [LOG_DEPTH_DFLT];
    int unsigned      head;
    int unsigned      fill;
    logic [CNT_W-1:0] counters [NUM_CNT];
    logic             capture_en;
    result_t          due_results [$];
    int               errors;

    function new();
      head       = 0;
      fill       = 0;
      capture_en = 1'b1;
      errors     = 0;
      foreach (counters[k]) counters[k] = '0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endfunction

    // update the predicted state for one accepted request
    function void note_request(action_t act, logic [IN_DATA_W-1:0] req);
      logic [1:0]  ftype;
      logic [3:0]  fsub;
      int unsigned n;
      int unsigned first;
      int unsigned i;
      result_t     res;

      ftype = req[15:14];
      fsub  = req[19:16];
      case (act)
        ACT_FRAME: begin
          // short frames and frames with capture off leave everything alone
          if (capture_en && req[11:0] >= HDR_BYTES) begin
            counters[CNT_TOTAL]++;
            if (ftype == FT_MGMT) begin
              counters[CNT_MGMT]++;
              if (fsub == SUB_DISASSOC || fsub == SUB_DEAUTH) counters[CNT_NOTABLE]++;
            end else if (ftype == FT_CTRL) begin
              counters[CNT_CTRL]++;
            end else if (ftype == FT_DATA) begin
              counters[CNT_DATA]++;
            end
            ring[head].ftype    = ftype;
            ring[head].subtype  = fsub;
            ring[head].address  = req[67:20];
            ring[head].strength = req[75:68];
            ring[head].channel  = req[79:76];
            head = (head + 1) % LOG_DEPTH_DFLT;
            if (fill < LOG_DEPTH_DFLT) fill++;
          end
        end
        ACT_DRAIN: begin
          // oldest entry first, then the ring is empty
          n     = fill;
          first = (head + LOG_DEPTH_DFLT - n) % LOG_DEPTH_DFLT;
          for (i = 0; i < n; i++) begin
            res            = '0;
            res.kind       = KIND_ENTRY;
            res.word.entry = ring[(first + i) % LOG_DEPTH_DFLT];
            res.last       = (i + 1 == n);
            due_results.push_back(res);
          end
          head = 0;
          fill = 0;
        end
        ACT_READ: begin
          res               = '0;
          res.kind          = KIND_REPORT;
          res.last          = 1'b1;
          res.word.total    = counters[CNT_TOTAL];
          res.word.mgmt     = counters[CNT_MGMT];
          res.word.ctrl     = counters[CNT_CTRL];
          res.word.data_cnt = counters[CNT_DATA];
          res.word.notable  = counters[CNT_NOTABLE];
          due_results.push_back(res);
        end
        default: begin
          foreach (counters[k]) counters[k] = '0;
          head = 0;
          fill = 0;
        end
      endcase
    endfunction

    // compare one accepted result with the oldest one due
    function void check_result(logic kind, logic last, out_word_t word);
      result_t want;

      if (due_results.size() == 0) begin
        report($sformatf("result with nothing due, kind %0b", kind));
        return;
      end
      want = due_results.pop_front();
      cmp("report_kind",      kind,                want.kind);
      cmp("is_last",          last,                want.last);
      cmp("logged_type",      word.entry.ftype,    want.word.entry.ftype);
      cmp("logged_subtype",   word.entry.subtype,  want.word.entry.subtype);
      cmp("logged_address",   word.entry.address,  want.word.entry.address);
      cmp("logged_strength",  word.entry.strength, want.word.entry.strength);
      cmp("logged_channel",   word.entry.channel,  want.word.entry.channel);
      cmp("total_count",      word.total,          want.word.total);
      cmp("management_count", word.mgmt,           want.word.mgmt);
      cmp("control_count",    word.ctrl,           want.word.ctrl);
      cmp("data_count",       word.data_cnt,       want.word.data_cnt);
      cmp("notable_count",    word.notable,        want.word.notable);
      cmp("padding",          word.pad,            want.word.pad);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Signals and block
  // -------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;

  classifier_scoreboard sb;
  int                   tx_idle;
  int                   rx_idle;
  int                   cycles;

  wlan_frame_classifier_log_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  always #CLK_HALF clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tlast, out_word_t'(out_tdata));
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic [IN_DATA_W-1:0] frame_word(logic [11:0] len, logic [7:0] fc,
                                                      logic [47:0] addr, logic [7:0] rssi,
                                                      logic [3:0] chan);
    return {chan, rssi, addr, fc, len};
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_noise();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[IN_DATA_W-1:0];
  endfunction

  // random frame, mostly long enough, biased towards notable management
  function automatic logic [IN_DATA_W-1:0] rand_frame(bit long_only);
    logic [11:0] len;
    logic [7:0]  fc;
    logic [1:0]  ver;

    if (!long_only && $urandom_range(99) < 15) len = 12'($urandom_range(23, 0));
    else if ($urandom_range(19) == 0)          len = 12'hFFF;
    else                                       len = 12'($urandom_range(4095, 24));
    ver = 2'($urandom);
    if ($urandom_range(99) < 20)
      fc = {($urandom_range(1) ? SUB_DEAUTH : SUB_DISASSOC), FT_MGMT, ver};
    else
      fc = 8'($urandom);
    return frame_word(len, fc, {16'($urandom), 32'($urandom)}, 8'($urandom), 4'($urandom));
  endfunction

  // one request; valid stays high for a back-to-back follower
  task automatic send_req(input action_t act, input logic [IN_DATA_W-1:0] req);
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, req);
  endtask

  task automatic send_frame(input logic [11:0] len, input logic [7:0] fc,
                            input logic [47:0] addr, input logic [7:0] rssi,
                            input logic [3:0] chan);
    send_req(ACT_FRAME, frame_word(len, fc, addr, rssi, chan));
  endtask

  task automatic send_random();
    action_t     act;
    int unsigned pick;

    pick = $urandom_range(99);
    if (pick < 65)      act = ACT_FRAME;
    else if (pick < 77) act = ACT_DRAIN;
    else if (pick < 92) act = ACT_READ;
    else                act = ACT_CLEAR;
    send_req(act, (act == ACT_FRAME) ? rand_frame(1'b0) : rand_noise());
  endtask

  // stop sending, wait for every due result, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_capture(input logic en);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.capture_en = en;
  endtask

  // a few random requests with capture switched off
  task automatic capture_off_run(input int n);
    wait_idle();
    write_capture(1'b0);
    repeat (n) send_random();
    wait_idle();
    write_capture(1'b1);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ACT_FRAME;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    tx_idle    = 0;
    rx_idle    = 0;
    cycles     = 0;
    sb         = new();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_capture(1'b1);

    // directed: reset counters, empty drain, short frames, every class
    send_req(ACT_READ, rand_noise());
    send_req(ACT_DRAIN, rand_noise());
    send_frame(12'd0,   {SUB_DEAUTH, FT_MGMT, 2'b00}, 48'h0123_4567_89AB, 8'h10, 4'd1);
    send_frame(12'd23,  {SUB_DISASSOC, FT_MGMT, 2'b00}, 48'h0, 8'h00, 4'd2);
    send_frame(12'd24,  {SUB_DISASSOC, FT_MGMT, 2'b00}, 48'h0, 8'h80, 4'd0);
    send_frame(12'hFFF, {SUB_DEAUTH, FT_MGMT, 2'b00}, 48'hFFFF_FFFF_FFFF, 8'h7F, 4'd15);
    send_frame(12'd60,  {4'd0, FT_MGMT, 2'b11}, 48'hA5A5_5A5A_A5A5, 8'hC4, 4'd6);
    send_frame(12'd30,  {SUB_DISASSOC, FT_CTRL, 2'b00}, 48'h5A5A_A5A5_5A5A, 8'hFF, 4'd11);
    send_frame(12'd1500, {SUB_DEAUTH, FT_DATA, 2'b00}, 48'h8000_0000_0001, 8'h01, 4'd7);
    send_frame(12'd200, {4'hF, FT_RSVD, 2'b00}, 48'h0000_FFFF_0000, 8'hB0, 4'd13);
    send_frame(12'd25,  8'hFF, 48'hFFFF_0000_FFFF, 8'h4E, 4'd8);
    send_req(ACT_READ, rand_noise());
    send_req(ACT_DRAIN, rand_noise());
    send_req(ACT_DRAIN, rand_noise());
    send_req(ACT_READ, rand_noise());
    send_frame(12'd64,  {4'd0, FT_DATA, 2'b00}, 48'h1234_5678_9ABC, 8'hD8, 4'd3);
    send_req(ACT_CLEAR, rand_noise());
    send_req(ACT_READ, rand_noise());
    send_req(ACT_DRAIN, rand_noise());

    // directed: capture off ignores frames, drain/read/clear still work
    wait_idle();
    write_capture(1'b0);
    send_frame(12'd100, {SUB_DEAUTH, FT_MGMT, 2'b00}, 48'hCAFE_0000_BEEF, 8'hA0, 4'd9);
    send_req(ACT_READ, rand_noise());
    send_req(ACT_DRAIN, rand_noise());
    send_req(ACT_CLEAR, rand_noise());
    wait_idle();
    write_capture(1'b1);
    send_frame(12'd80,  {SUB_DISASSOC, FT_MGMT, 2'b01}, 48'h0F0F_F0F0_0F0F, 8'hE2, 4'd4);
    send_req(ACT_READ, rand_noise());
    send_req(ACT_DRAIN, rand_noise());

    // random: three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      tx_idle = (ph == 0) ? 24 : (ph == 1) ? 54 : 0;
      rx_idle = (ph == 0) ? 54 : (ph == 1) ? 24 : 0;
      if (ph == 0) begin
        // overfill the ring so the oldest entries get overwritten
        repeat (LOG_DEPTH_DFLT + 2) send_req(ACT_FRAME, rand_frame(1'b1));
        send_req(ACT_DRAIN, rand_noise());
        send_req(ACT_READ, rand_noise());
      end
      repeat ((ph == 0) ? 4 : 8) send_random();
      capture_off_run(5);
    end

    wait_idle();
    if (sb.errors + sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
